FILE: sv/matrix_quarter_turn_rotator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix quarter-turn rotator
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_QUARTER_TURN_ROTATOR_MACROS_SVH
`define MATRIX_QUARTER_TURN_ROTATOR_MACROS_SVH

// Condition that must hold in the same cycle.
`define MQTR_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define MQTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mqtr_pkg.sv
// ----------------------------------------------------------------------------
// mqtr_pkg
// Widths, register indexes and codes of the matrix quarter-turn rotator.
// ----------------------------------------------------------------------------
package mqtr_pkg;

    localparam int MAX_DIM_DEFAULT = 64;

    localparam int VALUE_W   = 32;   // element value
    localparam int DIM_CFG_W = 7;    // row_count / col_count registers
    localparam int TURN_W    = 2;    // quarter_turns register
    localparam int POS_W     = 6;    // out_row / out_col fields
    localparam int CFG_IDX_W = 2;

    // tdata widths, padded to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;
    localparam int M_PAD_W   = M_TDATA_W - VALUE_W - 2 * POS_W;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_ROW_COUNT     = 2'd0;
    localparam cfg_idx_t CFG_COL_COUNT     = 2'd1;
    localparam cfg_idx_t CFG_QUARTER_TURNS = 2'd2;

    typedef logic [0:0] func_t;
    localparam func_t FUNC_LOAD = 1'b0;
    localparam func_t FUNC_EMIT = 1'b1;

    typedef logic [TURN_W-1:0] turn_t;
    localparam turn_t TURN_NONE  = 2'd0;
    localparam turn_t TURN_CW90  = 2'd1;
    localparam turn_t TURN_180   = 2'd2;
    localparam turn_t TURN_CW270 = 2'd3;

endpackage

FILE: sv/matrix_quarter_turn_rotator.sv
// An emit beat shows its result on m_* in the cycle after acceptance.
// Throughput: one beat per cycle, loads and emits alike, while m_* is not stalled;
//   set by the single store access per beat (write for load, registered read for emit).
// Reset (rst_n, async, active low): counters, load-done flag and output valid
//   clear, registers return to 1 x 1 and no turn. The store is not cleared.
// ----------------------------------------------------------------------------
// Matrix quarter-turn rotator
// Loads a row-major matrix into a block store, then streams it back turned
// clockwise by 0, 90, 180 or 270 degrees with row, column and a last mark.
// ----------------------------------------------------------------------------
`include "matrix_quarter_turn_rotator_macros.svh"

module matrix_quarter_turn_rotator #(
    parameter int MAX_DIM = mqtr_pkg::MAX_DIM_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // Configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  mqtr_pkg::cfg_idx_t             cfg_index,
    input  logic [mqtr_pkg::DIM_CFG_W-1:0] cfg_data,

    // Input beats
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mqtr_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] elem_value
    input  logic                           s_tuser,   // [0] func

    // Result beats
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mqtr_pkg::M_TDATA_W-1:0] m_tdata,   // [31:0] out_value,
                                                      // [37:32] out_row,
                                                      // [43:38] out_col, [47:44] 0
    output logic                           m_tlast    // last
);
    import mqtr_pkg::*;

    // Counter and address widths. Store rows are padded to a power of two so
    // the address is a plain concatenation of row and column.
    localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W  = DIM_W + 1;      // holds 1..MAX_DIM
    localparam int SRC_W  = DIM_W + 2;      // source coordinates, may go negative
    localparam int ADDR_W = 2 * DIM_W;
    localparam int DEPTH  = 1 << ADDR_W;

    // ------------------------------------------------------------------
    // Configuration registers (to be written only while idle, unenforced; always ready)
    // ------------------------------------------------------------------
    logic [DIM_CFG_W-1:0] row_count_reg, row_count_next;
    logic [DIM_CFG_W-1:0] col_count_reg, col_count_next;
    turn_t                quarter_turns_reg, quarter_turns_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        row_count_next     = row_count_reg;
        col_count_next     = col_count_reg;
        quarter_turns_next = quarter_turns_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ROW_COUNT:     row_count_next     = cfg_data;
                CFG_COL_COUNT:     col_count_next     = cfg_data;
                CFG_QUARTER_TURNS: quarter_turns_next = TURN_W'(cfg_data);
                default:           ;   // index beyond the list: dropped
            endcase
        end
    end

    // Dimensions clamped to 1..MAX_DIM; a zero acts as one.
    logic [CNT_W-1:0] dim_r, dim_c, turned_rows, turned_cols;

    always_comb
    begin
        if (row_count_reg == '0)
            dim_r = CNT_W'(1);
        else if (32'(row_count_reg) > MAX_DIM)
            dim_r = CNT_W'(MAX_DIM);
        else
            dim_r = CNT_W'(row_count_reg);

        if (col_count_reg == '0)
            dim_c = CNT_W'(1);
        else if (32'(col_count_reg) > MAX_DIM)
            dim_c = CNT_W'(MAX_DIM);
        else
            dim_c = CNT_W'(col_count_reg);
    end

    // Odd turn counts swap rows and columns.
    assign turned_rows = quarter_turns_reg[0] ? dim_c : dim_r;
    assign turned_cols = quarter_turns_reg[0] ? dim_r : dim_c;

    // ------------------------------------------------------------------
    // Beat classification
    // ------------------------------------------------------------------
    logic out_valid_reg, out_valid_next;
    logic load_done_reg, load_done_next;
    logic in_fire, is_load, load_fire, emit_fire;

    // Output register parts the sides: a new beat enters when no result is
    // pending or when the pending result leaves in the same cycle.
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign is_load   = (s_tuser == FUNC_LOAD);
    assign load_fire = in_fire && is_load && !load_done_reg;   // loads past the end drop
    assign emit_fire = in_fire && !is_load && load_done_reg;   // early emits give nothing

    // ------------------------------------------------------------------
    // Load counters
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] load_row_reg, load_row_next;
    logic [DIM_W-1:0] load_col_reg, load_col_next;
    logic [CNT_W-1:0] load_col_inc, load_row_inc;

    assign load_col_inc = CNT_W'(load_col_reg) + CNT_W'(1);
    assign load_row_inc = CNT_W'(load_row_reg) + CNT_W'(1);

    // ------------------------------------------------------------------
    // Emit counters and source mapping
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] emit_row_reg, emit_row_next;
    logic [DIM_W-1:0] emit_col_reg, emit_col_next;
    logic [CNT_W-1:0] emit_col_inc, emit_row_inc;
    logic [SRC_W-1:0] rows_m1, cols_m1, src_r, src_c;
    logic             src_oob, emit_last;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    assign emit_col_inc = CNT_W'(emit_col_reg) + CNT_W'(1);
    assign emit_row_inc = CNT_W'(emit_row_reg) + CNT_W'(1);
    assign rows_m1      = SRC_W'(dim_r) - SRC_W'(1);
    assign cols_m1      = SRC_W'(dim_c) - SRC_W'(1);

    // Turned (a,b) takes source (R-1-b,a), (R-1-a,C-1-b) or (b,C-1-a).
    always_comb
    begin
        case (quarter_turns_reg)
            TURN_NONE:
            begin
                src_r = SRC_W'(emit_row_reg);
                src_c = SRC_W'(emit_col_reg);
            end
            TURN_CW90:
            begin
                src_r = rows_m1 - SRC_W'(emit_col_reg);
                src_c = SRC_W'(emit_row_reg);
            end
            TURN_180:
            begin
                src_r = rows_m1 - SRC_W'(emit_row_reg);
                src_c = cols_m1 - SRC_W'(emit_col_reg);
            end
            default:
            begin
                src_r = SRC_W'(emit_col_reg);
                src_c = cols_m1 - SRC_W'(emit_row_reg);
            end
        endcase
    end

    // Negative coordinates wrap to large values and land here too; such a
    // position only arises when dimensions or the turn change mid-matrix, and reads zero.
    assign src_oob   = (src_r >= SRC_W'(MAX_DIM)) || (src_c >= SRC_W'(MAX_DIM));
    assign rd_addr   = {src_r[DIM_W-1:0], src_c[DIM_W-1:0]};
    assign wr_addr   = {load_row_reg, load_col_reg};
    assign emit_last = (emit_col_inc >= turned_cols) && (emit_row_inc >= turned_rows);

    always_comb
    begin
        load_row_next  = load_row_reg;
        load_col_next  = load_col_reg;
        load_done_next = load_done_reg;
        emit_row_next  = emit_row_reg;
        emit_col_next  = emit_col_reg;

        if (load_fire)
        begin
            if (load_col_inc >= dim_c)
            begin
                load_col_next = '0;
                // Truncation only matters once done, when the row is unused.
                load_row_next = DIM_W'(load_row_inc);
                if (load_row_inc >= dim_r)
                    load_done_next = 1'b1;
            end
            else
            begin
                load_col_next = DIM_W'(load_col_inc);
            end
        end

        if (emit_fire)
        begin
            if (emit_col_inc >= turned_cols)
            begin
                emit_col_next = '0;
                if (emit_row_inc >= turned_rows)
                begin
                    // Final element: rearm for the next matrix.
                    emit_row_next  = '0;
                    load_row_next  = '0;
                    load_col_next  = '0;
                    load_done_next = 1'b0;
                end
                else
                begin
                    emit_row_next = DIM_W'(emit_row_inc);
                end
            end
            else
            begin
                emit_col_next = DIM_W'(emit_col_inc);
            end
        end
    end

    // Output valid: set by an emit, cleared when the result is taken.
    always_comb
    begin
        if (emit_fire)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg     <= DIM_CFG_W'(1);
            col_count_reg     <= DIM_CFG_W'(1);
            quarter_turns_reg <= TURN_NONE;
            load_row_reg      <= '0;
            load_col_reg      <= '0;
            load_done_reg     <= 1'b0;
            emit_row_reg      <= '0;
            emit_col_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            row_count_reg     <= row_count_next;
            col_count_reg     <= col_count_next;
            quarter_turns_reg <= quarter_turns_next;
            load_row_reg      <= load_row_next;
            load_col_reg      <= load_col_next;
            load_done_reg     <= load_done_next;
            emit_row_reg      <= emit_row_next;
            emit_col_reg      <= emit_col_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Result side-band, captured with the read.
    logic [POS_W-1:0] out_row_reg, out_col_reg;
    logic             out_last_reg, out_zero_reg;

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_row_reg  <= POS_W'(emit_row_reg);
            out_col_reg  <= POS_W'(emit_col_reg);
            out_last_reg <= emit_last;
            out_zero_reg <= src_oob;
        end
    end

    // ------------------------------------------------------------------
    // Element store: one write (load) or one read (emit) per cycle.
    // A load and an emit never share a beat, and a read in the cycle after
    // the last write already sees it, so no forwarding is needed.
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0] store_mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (load_fire)
            store_mem[wr_addr] <= s_tdata[VALUE_W-1:0];
    end

    // Read register only moves on an emit, so it holds under back-pressure.
    always_ff @(posedge clk)
    begin
        if (emit_fire)
            rd_data_reg <= store_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Result port
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0] out_value;

    assign out_value = out_zero_reg ? '0 : rd_data_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tlast   = out_last_reg;
    assign m_tdata   = {{M_PAD_W{1'b0}}, out_col_reg, out_row_reg, out_value};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MQTR_ASSERT_NEXT(a_emit_gives_result, emit_fire, out_valid_reg, "emit beat lost its result")
    `MQTR_ASSERT_NEXT(a_last_rearms, emit_fire && emit_last,
        !load_done_reg && load_row_reg == '0 && load_col_reg == '0 &&
        emit_row_reg == '0 && emit_col_reg == '0, "counters not cleared after last element")
    `MQTR_ASSERT_ALWAYS(a_emit_idle_while_loading,
        load_done_reg || (emit_row_reg == '0 && emit_col_reg == '0),
        "emit counters moved before loading completed")
    `MQTR_ASSERT_NEXT(a_stall_holds_result, out_valid_reg && !m_tready,
        out_valid_reg && $stable(m_tdata) && $stable(m_tlast), "result changed under back-pressure")

endmodule

FILE: tb/matrix_quarter_turn_rotator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Matrix quarter-turn rotator testbench
// Loads matrices through the input stream, reads them back turned and checks
// every result beat against an in-bench rotation predictor or a typed value.
// Opens with a short table of directed beats, then runs random matrices with
// random idling on both streams and occasional mid-matrix register changes.
// ----------------------------------------------------------------------------
module matrix_quarter_turn_rotator_tb;
    import mqtr_pkg::*;

    localparam int DIM          = MAX_DIM_DEFAULT;
    localparam int RANDOM_ITEMS = 1950;
    localparam int STALL_LIMIT  = 4000;   // cycles with no beat on any channel
    localparam int DRAIN_CYCLES = 8;      // result shows in the cycle after the emit beat

    // One element of the turned matrix, as it leaves on m_*.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic               last;
    } turned_elem_t;

    typedef enum logic {DO_CFG, DO_BEAT} row_kind_t;

    // How the result of a beat is known: from the predictor, typed into the table, or none.
    typedef enum logic [1:0] {BY_PREDICTOR, NO_RESULT, TYPED} check_t;

    typedef struct packed {
        row_kind_t          kind;
        cfg_idx_t           reg_idx;
        logic [6:0]         reg_val;
        func_t              fn;
        logic [VALUE_W-1:0] val;
        check_t             how;
        turned_elem_t       want;
    } plan_row_t;

    localparam turned_elem_t NO_ELEM = '0;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_idx_t             cfg_index = CFG_ROW_COUNT;
    logic [DIM_CFG_W-1:0] cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    always #6 clk = ~clk;

    matrix_quarter_turn_rotator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // ------------------------------------------------------------------------
    // Rotation predictor: own copy of the store, counters and registers.
    // ------------------------------------------------------------------------
    logic [VALUE_W-1:0]   src_ram [0:DIM*DIM-1];
    int unsigned          wr_row = 0, wr_col = 0;   // next element to load
    int unsigned          rd_row = 0, rd_col = 0;   // next turned element to emit
    bit                   matrix_full = 1'b0;
    logic [DIM_CFG_W-1:0] reg_rows  = 7'd1;
    logic [DIM_CFG_W-1:0] reg_cols  = 7'd1;
    turn_t                reg_turns = TURN_NONE;

    initial foreach (src_ram[i]) src_ram[i] = '0;

    // Returns 1 when the beat yields a turned element; took flags any state effect.
    function automatic bit rotate_step(input func_t fn, input logic [VALUE_W-1:0] val,
                                       output turned_elem_t elem, output bit took);
        int unsigned nr, nc, orows, ocols, sr, sc, a, b;
        // zero acts as one, anything past the store edge acts as the edge
        nr = (reg_rows == 0) ? 1 : ((reg_rows > DIM) ? DIM : reg_rows);
        nc = (reg_cols == 0) ? 1 : ((reg_cols > DIM) ? DIM : reg_cols);
        elem = NO_ELEM;
        took = 1'b0;
        if (fn == FUNC_LOAD)
        begin
            if (matrix_full)
                return 1'b0;    // loads past the last element are dropped
            took = 1'b1;
            if (wr_row < DIM && wr_col < DIM)
                src_ram[wr_row * DIM + wr_col] = val;
            wr_col++;
            if (wr_col >= nc)
            begin
                wr_col = 0;
                wr_row++;
                if (wr_row >= nr)
                    matrix_full = 1'b1;
            end
            return 1'b0;
        end
        if (!matrix_full)
            return 1'b0;        // emit before the matrix is complete
        took  = 1'b1;
        orows = reg_turns[0] ? nc : nr;
        ocols = reg_turns[0] ? nr : nc;
        a     = rd_row;
        b     = rd_col;
        // unsigned wrap sends out-of-range positions past the store, reading zero
        case (reg_turns)
            TURN_NONE:
            begin
                sr = a;
                sc = b;
            end
            TURN_CW90:
            begin
                sr = nr - 1 - b;
                sc = a;
            end
            TURN_180:
            begin
                sr = nr - 1 - a;
                sc = nc - 1 - b;
            end
            default:
            begin
                sr = b;
                sc = nc - 1 - a;
            end
        endcase
        elem.value = (sr < DIM && sc < DIM) ? src_ram[sr * DIM + sc] : '0;
        elem.row   = a[POS_W-1:0];
        elem.col   = b[POS_W-1:0];
        rd_col++;
        if (rd_col >= ocols)
        begin
            rd_col = 0;
            rd_row++;
            if (rd_row >= orows)
            begin
                elem.last   = 1'b1;
                rd_row      = 0;
                wr_row      = 0;
                wr_col      = 0;
                matrix_full = 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Shared state between driver and monitor
    // ------------------------------------------------------------------------
    turned_elem_t turned_q [$];           // turned elements still owed by the block
    check_t       cur_check = BY_PREDICTOR;
    turned_elem_t cur_want  = NO_ELEM;
    bit           steady    = 1'b0;       // no idling on either side while set
    int           eff_items = 0;          // beats that loaded, emitted or moved state
    int           mats_done = 0;
    int           n_loads = 0, n_emits = 0, n_results = 0, n_cfg = 0;
    int           fails = 0;
    int           quiet_cycles = 0;

    // Receiver side: stall about a third of the time outside the steady stretch.
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= 33);

    // ------------------------------------------------------------------------
    // Monitor. Samples at the falling edge, where every signal is settled for
    // the coming rising edge: a beat seen here is the beat taken there. Input
    // is handled before output so a same-cycle result would still line up.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : watch
        bit           has, took;
        turned_elem_t nxt, got, w;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ROW_COUNT:     reg_rows  = cfg_data;
                    CFG_COL_COUNT:     reg_cols  = cfg_data;
                    CFG_QUARTER_TURNS: reg_turns = cfg_data[TURN_W-1:0];
                    default: ;
                endcase
                n_cfg++;
            end

            if (s_tvalid && s_tready)
            begin
                has = rotate_step(func_t'(s_tuser), s_tdata, nxt, took);
                if (took)
                    eff_items++;
                if (s_tuser == FUNC_LOAD)
                    n_loads++;
                else
                    n_emits++;
                if (cur_check == TYPED)
                    turned_q.push_back(cur_want);
                else if (cur_check == BY_PREDICTOR && has)
                    turned_q.push_back(nxt);
                if (has && nxt.last)
                    mats_done++;
            end

            if (m_tvalid && m_tready)
            begin
                got.value = m_tdata[VALUE_W-1:0];
                got.row   = m_tdata[VALUE_W +: POS_W];
                got.col   = m_tdata[VALUE_W+POS_W +: POS_W];
                got.last  = m_tlast;
                n_results++;
                if (turned_q.size() == 0)
                begin
                    $error("result beat with nothing pending: value %h row %0d col %0d",
                           got.value, got.row, got.col);
                    fails++;
                end
                else
                begin
                    w = turned_q.pop_front();
                    if (got.value !== w.value)
                    begin
                        $error("out_value: expected %h, got %h", w.value, got.value);
                        fails++;
                    end
                    if (got.row !== w.row)
                    begin
                        $error("out_row: expected %0d, got %0d", w.row, got.row);
                        fails++;
                    end
                    if (got.col !== w.col)
                    begin
                        $error("out_col: expected %0d, got %0d", w.col, got.col);
                        fails++;
                    end
                    if (got.last !== w.last)
                    begin
                        $error("last: expected %0b, got %0b", w.last, got.last);
                        fails++;
                    end
                end
            end

            // watchdog: any beat on any channel counts as progress
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: %0d cycles without a beat", STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Present one input beat, with random idle cycles ahead of it.
    task automatic send_beat(input func_t fn, input logic [VALUE_W-1:0] val,
                             input check_t how, input turned_elem_t want);
        bit hit;
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        cur_check = how;
        cur_want  = want;
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= val;
        hit = 1'b0;
        while (!hit)
        begin
            @(negedge clk);
            hit = s_tready;
            @(posedge clk);
        end
    endtask

    // Register write, only once every owed element is out and the block has settled.
    task automatic write_reg(input cfg_idx_t idx, input logic [DIM_CFG_W-1:0] val);
        bit hit;
        s_tvalid <= 1'b0;
        while (turned_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        hit = 1'b0;
        while (!hit)
        begin
            @(negedge clk);
            hit = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly tiny matrices, now and then up to 16, now and then a zero that acts as one.
    function automatic logic [DIM_CFG_W-1:0] rand_dim();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        if (pick < 14)
            return 7'($urandom_range(1, 4));
        return 7'($urandom_range(5, 16));
    endfunction

    // Turn count with junk in the upper bits, which the register must drop.
    function automatic logic [DIM_CFG_W-1:0] turn_data();
        return {5'($urandom_range(0, 31)), 2'($urandom_range(0, 3))};
    endfunction

    // ------------------------------------------------------------------------
    // Directed table. Typed rows: 1 x 1 straight after reset, value extremes and
    // the 1 x 2 quarter-turn-three case. The 2 x 3 single-turn block goes through
    // the predictor.
    // ------------------------------------------------------------------------
    plan_row_t dir_plan [26] = '{
        // emit before any load: nothing comes back
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_EMIT, 32'h0000_0000, NO_RESULT, NO_ELEM},
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_LOAD, 32'h8000_0000, NO_RESULT, NO_ELEM},
        // matrix already full: dropped
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_LOAD, 32'h7fff_ffff, NO_RESULT, NO_ELEM},
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_EMIT, 32'hffff_ffff, TYPED,
          '{32'h8000_0000, 6'd0, 6'd0, 1'b1}},
        // 2 x 3, one quarter turn, upper bits of the turn count set
        '{DO_CFG,  CFG_ROW_COUNT,     7'd2,        FUNC_LOAD, 32'h0, BY_PREDICTOR, NO_ELEM},
        '{DO_CFG,  CFG_COL_COUNT,     7'd3,        FUNC_LOAD, 32'h0, BY_PREDICTOR, NO_ELEM},
        '{DO_CFG,  CFG_QUARTER_TURNS, 7'b1111101,  FUNC_LOAD, 32'h0, BY_PREDICTOR, NO_ELEM},
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_LOAD, 32'h0000_0011, BY_PREDICTOR, NO_ELEM},
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_LOAD, 32'hffff_fffe, BY_PREDICTOR, NO_ELEM},
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_LOAD, 32'h0000_0033, BY_PREDICTOR, NO_ELEM},
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_LOAD, 32'ha5a5_5a5a, BY_PREDICTOR, NO_ELEM},
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_LOAD, 32'h0000_0055, BY_PREDICTOR, NO_ELEM},
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_LOAD, 32'h1234_5678, BY_PREDICTOR, NO_ELEM},
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_EMIT, 32'h0000_0000, BY_PREDICTOR, NO_ELEM},
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_EMIT, 32'hffff_ffff, BY_PREDICTOR, NO_ELEM},
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_EMIT, 32'h5555_5555, BY_PREDICTOR, NO_ELEM},
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_EMIT, 32'haaaa_aaaa, BY_PREDICTOR, NO_ELEM},
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_EMIT, 32'h0000_0001, BY_PREDICTOR, NO_ELEM},
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_EMIT, 32'h8000_0000, BY_PREDICTOR, NO_ELEM},
        // zero rows acts as one: 1 x 2 turned three times comes out 2 x 1, reversed
        '{DO_CFG,  CFG_ROW_COUNT,     7'd0, FUNC_LOAD, 32'h0, BY_PREDICTOR, NO_ELEM},
        '{DO_CFG,  CFG_COL_COUNT,     7'd2, FUNC_LOAD, 32'h0, BY_PREDICTOR, NO_ELEM},
        '{DO_CFG,  CFG_QUARTER_TURNS, 7'd3, FUNC_LOAD, 32'h0, BY_PREDICTOR, NO_ELEM},
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_LOAD, 32'h7fff_ffff, NO_RESULT, NO_ELEM},
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_LOAD, 32'h0000_0000, NO_RESULT, NO_ELEM},
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_EMIT, 32'h0000_0000, TYPED,
          '{32'h0000_0000, 6'd0, 6'd0, 1'b0}},
        '{DO_BEAT, CFG_ROW_COUNT, 7'd0, FUNC_EMIT, 32'hffff_ffff, TYPED,
          '{32'h7fff_ffff, 6'd1, 6'd0, 1'b1}}
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main
        int    seen, stage, target;
        func_t fn;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_plan[i])
        begin
            if (dir_plan[i].kind == DO_CFG)
                write_reg(dir_plan[i].reg_idx, dir_plan[i].reg_val);
            else
                send_beat(dir_plan[i].fn, dir_plan[i].val, dir_plan[i].how, dir_plan[i].want);
        end

        // First random matrix is 16 x 16: it fills every store entry that later
        // small shapes, including those changed mid-matrix, can ever read.
        // Then a 1 x 64 (zero rows, all-ones columns) and a 64 x 1 for the extremes,
        // then random small shapes.
        seen   = mats_done;
        stage  = 0;
        target = eff_items + RANDOM_ITEMS;
        write_reg(CFG_ROW_COUNT, 7'd16);
        write_reg(CFG_COL_COUNT, 7'd16);
        write_reg(CFG_QUARTER_TURNS, turn_data());
        while (eff_items < target)
        begin
            steady = (eff_items >= 900) && (eff_items < 1200);
            if (mats_done != seen)
            begin
                seen = mats_done;
                stage++;
                if (stage == 1)
                begin
                    write_reg(CFG_ROW_COUNT, 7'd0);
                    write_reg(CFG_COL_COUNT, 7'd127);
                    write_reg(CFG_QUARTER_TURNS, turn_data());
                end
                else if (stage == 2)
                begin
                    write_reg(CFG_ROW_COUNT, 7'd64);
                    write_reg(CFG_COL_COUNT, 7'd1);
                    write_reg(CFG_QUARTER_TURNS, turn_data());
                end
                else if ($urandom_range(0, 9) < 7)
                begin
                    write_reg(CFG_ROW_COUNT, rand_dim());
                    write_reg(CFG_COL_COUNT, rand_dim());
                    write_reg(CFG_QUARTER_TURNS, turn_data());
                end
            end
            else if (stage >= 3 && $urandom_range(0, 149) == 0)
            begin
                // shape or turn changed partway through a load or a read-out
                case ($urandom_range(0, 2))
                    0:       write_reg(CFG_ROW_COUNT, rand_dim());
                    1:       write_reg(CFG_COL_COUNT, rand_dim());
                    default: write_reg(CFG_QUARTER_TURNS, turn_data());
                endcase
            end
            // mostly well-formed load-then-emit runs, one beat in ten out of turn
            if (matrix_full)
                fn = ($urandom_range(0, 9) == 0) ? FUNC_LOAD : FUNC_EMIT;
            else
                fn = ($urandom_range(0, 9) == 0) ? FUNC_EMIT : FUNC_LOAD;
            send_beat(fn, $urandom(), BY_PREDICTOR, NO_ELEM);
        end

        steady = 1'b0;
        s_tvalid <= 1'b0;
        while (turned_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d load and %0d emit beats, %0d matrices turned, %0d register writes",
                 n_loads, n_emits, mats_done, n_cfg);
        $display("%0d result beats compared, %0d mismatches", n_results, fails);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/mqtr_pkg.sv
sv/matrix_quarter_turn_rotator.sv
tb/matrix_quarter_turn_rotator_tb.sv
